FILE: src/ghmos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmos_pkg
// Shared types, constants and the byte popcount used by the gallery
// minimum-over-shifts matcher.
// ----------------------------------------------------------------------------
package ghmos_pkg;

  typedef logic [15:0] count_t;

  localparam count_t COUNT_MAX = 16'hFFFF;

  // set bits in each nibble value
  localparam logic [2:0] NIBBLE_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  // last byte of an entry, handed from the accumulator to the fold stage
  typedef struct packed {
    logic [7:0] entry;
    count_t     count;
    logic       first_pass;
    logic       last_pass;
    logic       in_range;
  } fold_req_t;

  function automatic logic [3:0] byte_ones(input logic [7:0] b);
    return {1'b0, NIBBLE_ONES[b[3:0]]} + {1'b0, NIBBLE_ONES[b[7:4]]};
  endfunction

endpackage

FILE: src/ghmos_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghmos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ghmos_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmos_accum
// XOR and popcount of one byte pair, added to the saturating running
// mismatch count. The count restarts at zero after an entry's last byte.
// ----------------------------------------------------------------------------
module ghmos_accum (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          probe_byte,
  input  logic [7:0]          gallery_byte,
  input  logic                last_byte,
  output ghmos_pkg::count_t   count_sum
);

  ghmos_pkg::count_t running_count;
  logic [16:0]       sum;

  always_comb begin
    sum = {1'b0, running_count}
        + 17'(ghmos_pkg::byte_ones(probe_byte ^ gallery_byte));
    count_sum = sum[16] ? ghmos_pkg::COUNT_MAX : sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
    end else if (accept) begin
      running_count <= last_byte ? '0 : count_sum;
    end
  end

endmodule

FILE: src/ghmos_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmos_fold
// Read-modify-write of the per-entry minimum: takes the read data in the cycle
// after the request, forwards the most recent write, keeps the smaller count
// and writes it back. Owns the result word register.
// ----------------------------------------------------------------------------
module ghmos_fold #(
  parameter int ADDR_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  ghmos_pkg::fold_req_t   req,
  input  ghmos_pkg::count_t      rdata,
  output logic                   we,
  output logic [ADDR_W-1:0]      waddr,
  output ghmos_pkg::count_t      wdata,
  output logic                   blocked,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             result_entry,
  output logic [15:0]            min_mismatches
);

  localparam int EXT_W = (ADDR_W > 8) ? ADDR_W : 8;

  logic                 s1_valid;
  ghmos_pkg::fold_req_t s1_req;
  logic                 fwd_valid;
  logic [ADDR_W-1:0]    fwd_addr;
  ghmos_pkg::count_t    fwd_data;

  logic [EXT_W-1:0]     entry_ext;
  logic [ADDR_W-1:0]    addr;
  ghmos_pkg::count_t    prev;
  ghmos_pkg::count_t    best;
  logic                 emit;

  always_comb begin
    entry_ext = EXT_W'(s1_req.entry);
    addr      = entry_ext[ADDR_W-1:0];
    // the write issued on the read edge is not yet in the read data
    prev = (fwd_valid && fwd_addr == addr) ? fwd_data : rdata;
    if (s1_req.first_pass || !s1_req.in_range) begin
      best = s1_req.count;
    end else begin
      best = (prev < s1_req.count) ? prev : s1_req.count;
    end
    emit    = s1_valid && s1_req.last_pass;
    blocked = emit && out_valid && out_stall;
    we      = s1_valid && s1_req.in_range && !blocked;
    waddr   = addr;
    wdata   = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!blocked) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked && req_valid) begin
      s1_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr <= addr;
      fwd_data <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!(out_valid && out_stall)) begin
      out_valid <= emit;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk) begin
    if (!(out_valid && out_stall) && emit) begin
      result_entry   <= s1_req.entry;
      min_mismatches <= best;
    end
  end

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    blocked |=> s1_valid && $stable(s1_req))
    else $error("fold stage changed while blocked");

  a_best_bounded: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> best <= s1_req.count)
    else $error("minimum above current count");

  a_first_overwrites: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_req.first_pass |-> best == s1_req.count)
    else $error("first pass did not overwrite minimum");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result word without an emitting entry");

endmodule

FILE: src/gallery_hamming_min_over_shifts_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gallery_hamming_min_over_shifts_unit
// Minimum Hamming mismatch count per gallery entry over rotated probe passes.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle unless stalled; the minimum RAM is read
//   on the accepting edge and written back by the fold stage with forwarding.
// A result word goes through the fold stage into the result register.
// Output stall holds the fold stage and then the input, one word per cycle.
// Reset clears the running count and all valid flags; the minimum RAM is
//   not cleared and each entry is defined by its first-pass write.
module gallery_hamming_min_over_shifts_unit #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  probe_byte,
  input  logic [7:0]  gallery_byte,
  input  logic [7:0]  entry,
  input  logic        first_pass,
  input  logic        last_byte,
  input  logic        last_pass,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  result_entry,
  output logic [15:0] min_mismatches
);

  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int EXT_W  = (ADDR_W > 8) ? ADDR_W : 8;

  logic                 accept;
  logic                 req_valid;
  logic                 in_range;
  logic [EXT_W-1:0]     entry_ext;
  ghmos_pkg::count_t    count_sum;
  ghmos_pkg::fold_req_t req;
  ghmos_pkg::count_t    rdata;
  logic                 we;
  logic [ADDR_W-1:0]    waddr;
  ghmos_pkg::count_t    wdata;
  logic                 blocked;

  always_comb begin
    in_stall  = blocked;
    accept    = in_valid && !in_stall;
    req_valid = accept && last_byte;
    in_range  = {24'd0, entry} < 32'(MAX_ENTRIES);
    entry_ext = EXT_W'(entry);
    req.entry      = entry;
    req.count      = count_sum;
    req.first_pass = first_pass;
    req.last_pass  = last_pass;
    req.in_range   = in_range;
  end

  ghmos_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .probe_byte   (probe_byte),
    .gallery_byte (gallery_byte),
    .last_byte    (last_byte),
    .count_sum    (count_sum)
  );

  ghmos_ram #(
    .WIDTH  (16),
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_min_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req_valid && in_range),
    .raddr (entry_ext[ADDR_W-1:0]),
    .rdata (rdata)
  );

  ghmos_fold #(
    .ADDR_W (ADDR_W)
  ) u_fold (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req            (req),
    .rdata          (rdata),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .blocked        (blocked),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_entry   (result_entry),
    .min_mismatches (min_mismatches)
  );

endmodule

FILE: bench/tb_gallery_hamming_min_over_shifts_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gallery_hamming_min_over_shifts_unit
// Self-checking bench for the minimum-over-shifts matcher. Streams probe and
// gallery byte words, first directed cases and one long all-differing entry,
// then random multi-pass galleries mixed with loose words. Both handshake
// sides idle at random. A scoreboard class predicts each entry minimum and
// checks every result word in order.
// ----------------------------------------------------------------------------
module tb_gallery_hamming_min_over_shifts_unit;

  localparam int ENTRY_SLOTS  = 256;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 620;
  localparam int LONG_BYTES   = 96;
  localparam int TAIL_CYCLES  = 8;

  typedef struct {
    logic [7:0]         ent;
    ghmos_pkg::count_t  cnt;
  } entry_min_t;

  class MinMismatchBoard;
    ghmos_pkg::count_t run_count;
    ghmos_pkg::count_t best [ENTRY_SLOTS];
    entry_min_t        pending [$];
    int                errors;
    int                matched;

    function new();
      run_count = '0;
      errors    = 0;
      matched   = 0;
    endfunction

    // fold one accepted word into the predicted state
    function void note_word(input logic [7:0] probe, gal, ent, input logic fp, lb, lp);
      int                sum;
      ghmos_pkg::count_t pick;
      entry_min_t        r;
      sum = int'(run_count) + $countones(probe ^ gal);
      if (sum > int'(ghmos_pkg::COUNT_MAX)) sum = int'(ghmos_pkg::COUNT_MAX);
      if (!lb) begin
        run_count = ghmos_pkg::count_t'(sum);
        return;
      end
      run_count = '0;
      pick = ghmos_pkg::count_t'(sum);
      if (int'(ent) < ENTRY_SLOTS) begin
        if (!fp && best[ent] < pick) pick = best[ent];
        best[ent] = pick;
      end
      if (lp) begin
        r.ent = ent;
        r.cnt = pick;
        pending.push_back(r);
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(input logic [7:0] ent, input ghmos_pkg::count_t cnt);
      entry_min_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result entry %0d count %0d", ent, cnt));
        return;
      end
      want = pending.pop_front();
      if (ent !== want.ent)
        report($sformatf("result_entry %0d, want %0d", ent, want.ent));
      if (cnt !== want.cnt)
        report($sformatf("min_mismatches %0d for entry %0d, want %0d", cnt, want.ent, want.cnt));
      matched++;
    endtask

    function int waiting();
      return pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  probe_byte = '0;
  logic [7:0]  gallery_byte = '0;
  logic [7:0]  entry = '0;
  logic        first_pass = 1'b0;
  logic        last_byte = 1'b0;
  logic        last_pass = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  result_entry;
  logic [15:0] min_mismatches;

  MinMismatchBoard board;
  bit quiet = 1'b0;
  bit written [ENTRY_SLOTS];
  int words_sent = 0;
  int stall_run = 0;
  int cycles = 0;

  gallery_hamming_min_over_shifts_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .probe_byte     (probe_byte),
    .gallery_byte   (gallery_byte),
    .entry          (entry),
    .first_pass     (first_pass),
    .last_byte      (last_byte),
    .last_pass      (last_pass),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_entry   (result_entry),
    .min_mismatches (min_mismatches)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall and free bursts, none once quiet
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_word(result_entry, min_mismatches);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // probe byte close to the gallery byte, so minima spread out
  function automatic logic [7:0] probe_near(input logic [7:0] g);
    case ($urandom_range(0, 4))
      0: return g;
      1: return g ^ (8'h01 << $urandom_range(0, 7));
      2: return ~g;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // call aligned to a rising edge; returns at the accepting edge
  task automatic send_word(input logic [7:0] p, g, e, input logic fp, lb, lp,
                           input bit may_idle);
    if (may_idle) idle_gap();
    in_valid     <= 1'b1;
    probe_byte   <= p;
    gallery_byte <= g;
    entry        <= e;
    first_pass   <= fp;
    last_byte    <= lb;
    last_pass    <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(p, g, e, fp, lb, lp);
    words_sent++;
    if (lb && fp) written[e] = 1'b1;
  endtask

  // hold the sender until every predicted minimum has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.waiting() != 0) @(posedge clk);
  endtask

  task automatic run_gallery(input int n_ent, input int code_len, input int passes,
                             input bit cut_short);
    logic [7:0] ids [8];
    logic [7:0] code [8][8];
    logic       lp;
    for (int e = 0; e < n_ent; e++) begin
      ids[e] = 8'($urandom);
      for (int i = 0; i < code_len; i++) code[e][i] = pick_byte();
    end
    for (int p = 0; p < passes; p++) begin
      // a cut-short run never reaches its last pass
      lp = (p == passes - 1) && !cut_short;
      for (int e = 0; e < n_ent; e++)
        for (int i = 0; i < code_len; i++)
          send_word(probe_near(code[e][i]), code[e][i], ids[e], p == 0,
                    i == code_len - 1, lp, 1'b1);
    end
  endtask

  task automatic send_noise(input int n);
    logic [7:0] e;
    logic       fp;
    logic       lb;
    for (int k = 0; k < n; k++) begin
      e  = 8'($urandom);
      fp = 1'($urandom_range(0, 1));
      lb = ($urandom_range(0, 3) == 0);
      // never fold into a minimum that was never written
      if (lb && !fp && !written[e]) fp = 1'b1;
      send_word(pick_byte(), pick_byte(), e, fp, lb, 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  initial begin
    int start_count;
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single pass with both flags: equal bytes, then every bit differing
    send_word(8'h00, 8'h00, 8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
    send_word(8'hFF, 8'h00, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1);
    // three passes over two entries: minimum drops, then rises, then ties
    send_word(8'hFF, 8'h0F, 8'd3, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(8'hAA, 8'h55, 8'd3, 1'b1, 1'b1, 1'b0, 1'b1);
    send_word(8'h01, 8'h00, 8'd255, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(8'h00, 8'h00, 8'd255, 1'b1, 1'b1, 1'b0, 1'b1);
    send_word(8'h00, 8'h00, 8'd3, 1'b0, 1'b0, 1'b0, 1'b1);
    send_word(8'h00, 8'h01, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1);
    send_word(8'hFF, 8'h00, 8'd255, 1'b0, 1'b0, 1'b0, 1'b1);
    send_word(8'hFF, 8'h00, 8'd255, 1'b0, 1'b1, 1'b0, 1'b1);
    send_word(8'h80, 8'h00, 8'd3, 1'b0, 1'b0, 1'b1, 1'b1);
    send_word(8'h7F, 8'h00, 8'd3, 1'b0, 1'b1, 1'b1, 1'b1);
    send_word(8'h00, 8'h00, 8'd255, 1'b0, 1'b0, 1'b1, 1'b1);
    send_word(8'h00, 8'h01, 8'd255, 1'b0, 1'b1, 1'b1, 1'b1);
    wait_drained();

    // one long entry of all-differing bytes carries the count past eight bits
    for (int i = 0; i < LONG_BYTES; i++)
      send_word(8'hFF, 8'h00, 8'd7, 1'b1, i == LONG_BYTES - 1, 1'b1, 1'b0);
    wait_drained();

    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      if (words_sent - start_count > RANDOM_WORDS * 85 / 100) quiet = 1'b1;
      if ($urandom_range(0, 99) < 85)
        run_gallery($urandom_range(1, 6), $urandom_range(1, 8), $urandom_range(1, 4),
                    $urandom_range(0, 9) == 0);
      else
        send_noise($urandom_range(1, 8));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.waiting() != 0)
      board.report($sformatf("%0d expected results never arrived", board.waiting()));
    $display("sent %0d words: directed flags, a %0d-byte long entry, random galleries",
             words_sent, LONG_BYTES);
    $display("checked %0d entry minima with random idling on both sides", board.matched);
    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
src/ghmos_pkg.sv
src/ghmos_ram.sv
src/ghmos_accum.sv
src/ghmos_fold.sv
src/gallery_hamming_min_over_shifts_unit.sv
bench/tb_gallery_hamming_min_over_shifts_unit.sv
